// ----- hdl/reentrant_mutex_fifo_waiters_assert.svh -----
// Assertion macros for the recursive mutex block.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef REENTRANT_MUTEX_FIFO_WAITERS_ASSERT_SVH
`define REENTRANT_MUTEX_FIFO_WAITERS_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define RMFW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define RMFW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/rmfw_pkg.sv -----
// Shared types and constants for the recursive mutex block.
// No dependencies; used by the interfaces, the top level and the checker.
`default_nettype none

package rmfw_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_BITS_DEF     = 8;
    localparam int COUNT_BITS_DEF  = 8;

    localparam int ID_FIELD_W    = 8;
    localparam int COUNT_FIELD_W = 8;
    localparam int STATUS_W      = 4;

    localparam logic REQ_ACQUIRE = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED         = 4'd0,
        ST_REENTERED       = 4'd1,
        ST_BLOCKED         = 4'd2,
        ST_LOWERED         = 4'd3,
        ST_FREED           = 4'd4,
        ST_NOT_HOLDER      = 4'd5,
        ST_QUEUE_FULL      = 4'd6,
        ST_ALREADY_WAITING = 4'd7,
        ST_OVERFLOW        = 4'd8
    } status_t;

endpackage

`default_nettype wire

// ----- hdl/mutex_req_if.sv -----
// Request and response channel interfaces of the recursive mutex block.
// Depends on rmfw_pkg for field widths.
`default_nettype none

interface mutex_req_if;
    import rmfw_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  req_type;
    logic [ID_FIELD_W-1:0] thread_id;

    modport source (output valid, output req_type, output thread_id, input ready);
    modport sink   (input valid, input req_type, input thread_id, output ready);
endinterface

interface mutex_rsp_if;
    import rmfw_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic                     woken_valid;
    logic [ID_FIELD_W-1:0]    woken_id;
    logic                     held_now;
    logic [COUNT_FIELD_W-1:0] repeat_now;

    modport source (output valid, output status, output woken_valid, output woken_id,
                    output held_now, output repeat_now, input ready);
    modport sink   (input valid, input status, input woken_valid, input woken_id,
                    input held_now, input repeat_now, output ready);
endinterface

`default_nettype wire

// ----- hdl/reentrant_mutex_fifo_waiters.sv -----
// Recursive mutex with FIFO wait queue. An accepted request has its memory reads
// registered, then S_LOOK resolves it into the output register. No new request is
// taken before the last is resolved, and a stalled response holds the next one back.
// Reset: rst_n clears lock, queue pointers and output valid at once, then a clearing
// pass zeroes all 2**ID_BITS waiter marks (256 by default); no request is taken
// during that pass. Depends on rmfw_pkg, mutex_req_if and mutex_rsp_if.
`default_nettype none

module reentrant_mutex_fifo_waiters #(
    parameter int QUEUE_DEPTH = rmfw_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = rmfw_pkg::ID_BITS_DEF,
    parameter int COUNT_BITS  = rmfw_pkg::COUNT_BITS_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    mutex_req_if.sink   req,
    mutex_rsp_if.source rsp
);
    import rmfw_pkg::*;

    localparam int PTR_W      = $clog2(QUEUE_DEPTH);
    localparam int FILL_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int MARK_DEPTH = 1 << ID_BITS;

    // Sequencer: clear the mark memory, wait for a request, then resolve it
    // once the memory read data is back.
    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_LOOK  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // Lock and queue control state.
    logic                  holder_valid_reg, holder_valid_next;
    logic [ID_BITS-1:0]    holder_id_reg, holder_id_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [PTR_W-1:0]      head_reg, head_next;
    logic [PTR_W-1:0]      tail_reg, tail_next;
    logic [FILL_W-1:0]     fill_reg, fill_next;
    logic [ID_BITS-1:0]    clr_idx_reg, clr_idx_next;

    // Captured request.
    logic                  req_type_reg;
    logic [ID_BITS-1:0]    tid_reg;

    // Memories and their registered read data.
    logic                  mark_mem [MARK_DEPTH];
    logic [ID_BITS-1:0]    queue_mem [QUEUE_DEPTH];
    logic                  mark_rd_reg;
    logic [ID_BITS-1:0]    queue_rd_reg;

    // Output register.
    logic                  out_valid_reg, out_valid_next;
    status_t               status_reg, status_next;
    logic                  woken_valid_reg, woken_valid_next;
    logic [ID_BITS-1:0]    woken_id_reg, woken_id_next;

    // Write ports.
    logic                  mark_we;
    logic [ID_BITS-1:0]    mark_wa;
    logic                  mark_wd;
    logic                  queue_we;

    logic                  req_accept;
    logic                  look_fire;
    logic [ID_BITS-1:0]    in_tid;
    logic                  holder_match;

    // Only the low ID_BITS of the thread id take part.
    assign in_tid = ID_BITS'(req.thread_id);

    assign req.ready  = (state_reg == S_IDLE);
    assign req_accept = req.valid && req.ready;

    // Resolve the request only when the output register can take the result.
    assign look_fire  = (state_reg == S_LOOK) && (!out_valid_reg || rsp.ready);

    assign holder_match = holder_valid_reg && (holder_id_reg == tid_reg);

    always_comb
    begin
        state_next        = state_reg;
        clr_idx_next      = clr_idx_reg;
        holder_valid_next = holder_valid_reg;
        holder_id_next    = holder_id_reg;
        count_next        = count_reg;
        head_next         = head_reg;
        tail_next         = tail_reg;
        fill_next         = fill_reg;
        status_next       = status_reg;
        woken_valid_next  = woken_valid_reg;
        woken_id_next     = woken_id_reg;
        mark_we           = 1'b0;
        mark_wa           = tid_reg;
        mark_wd           = 1'b0;
        queue_we          = 1'b0;

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                mark_we      = 1'b1;
                mark_wa      = clr_idx_reg;
                mark_wd      = 1'b0;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == {ID_BITS{1'b1}})
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_accept)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (look_fire)
                begin
                    state_next       = S_IDLE;
                    out_valid_next   = 1'b1;
                    woken_valid_next = 1'b0;
                    woken_id_next    = '0;
                    if (req_type_reg == REQ_ACQUIRE)
                    begin
                        priority if (holder_match)
                        begin
                            if (count_reg == {COUNT_BITS{1'b1}})
                            begin
                                status_next = ST_OVERFLOW;
                            end
                            else
                            begin
                                count_next  = count_reg + 1'b1;
                                status_next = ST_REENTERED;
                            end
                        end
                        else if (mark_rd_reg)
                        begin
                            status_next = ST_ALREADY_WAITING;
                        end
                        else if (!holder_valid_reg)
                        begin
                            holder_valid_next = 1'b1;
                            holder_id_next    = tid_reg;
                            count_next        = COUNT_BITS'(1);
                            status_next       = ST_GRANTED;
                        end
                        else if (fill_reg == FILL_W'(QUEUE_DEPTH))
                        begin
                            status_next = ST_QUEUE_FULL;
                        end
                        else
                        begin
                            // Append to the queue and mark the id as waiting.
                            queue_we    = 1'b1;
                            mark_we     = 1'b1;
                            mark_wa     = tid_reg;
                            mark_wd     = 1'b1;
                            fill_next   = fill_reg + 1'b1;
                            tail_next   = (tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ?
                                          '0 : tail_reg + 1'b1;
                            status_next = ST_BLOCKED;
                        end
                    end
                    else
                    begin
                        priority if (!holder_match)
                        begin
                            status_next = ST_NOT_HOLDER;
                        end
                        else if (count_reg > COUNT_BITS'(1))
                        begin
                            count_next  = count_reg - 1'b1;
                            status_next = ST_LOWERED;
                        end
                        else
                        begin
                            holder_valid_next = 1'b0;
                            holder_id_next    = '0;
                            count_next        = '0;
                            status_next       = ST_FREED;
                            if (fill_reg != '0)
                            begin
                                // Pop the head waiter and drop its mark.
                                mark_we          = 1'b1;
                                mark_wa          = queue_rd_reg;
                                mark_wd          = 1'b0;
                                fill_next        = fill_reg - 1'b1;
                                head_next        = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ?
                                                   '0 : head_reg + 1'b1;
                                woken_valid_next = 1'b1;
                                woken_id_next    = queue_rd_reg;
                            end
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_idx_reg      <= '0;
            holder_valid_reg <= 1'b0;
            holder_id_reg    <= '0;
            count_reg        <= '0;
            head_reg         <= '0;
            tail_reg         <= '0;
            fill_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_idx_reg      <= clr_idx_next;
            holder_valid_reg <= holder_valid_next;
            holder_id_reg    <= holder_id_next;
            count_reg        <= count_next;
            head_reg         <= head_next;
            tail_reg         <= tail_next;
            fill_reg         <= fill_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge clk)
    begin
        status_reg      <= status_next;
        woken_valid_reg <= woken_valid_next;
        woken_id_reg    <= woken_id_next;
        if (req_accept)
        begin
            req_type_reg <= req.req_type;
            tid_reg      <= in_tid;
        end
    end

    // Waiter-mark memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mark_we)
        begin
            mark_mem[mark_wa] <= mark_wd;
        end
        if (req_accept)
        begin
            mark_rd_reg <= mark_mem[in_tid];
        end
    end

    // Waiter queue memory: write at the tail, read the head on accept.
    always_ff @(posedge clk)
    begin
        if (queue_we)
        begin
            queue_mem[tail_reg] <= tid_reg;
        end
        if (req_accept)
        begin
            queue_rd_reg <= queue_mem[head_reg];
        end
    end

    // Held state after the step is the live lock state while the result waits,
    // since no other request is resolved until the result has been taken.
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.woken_valid = woken_valid_reg;
    assign rsp.woken_id    = ID_FIELD_W'(woken_id_reg);
    assign rsp.held_now    = holder_valid_reg;
    assign rsp.repeat_now  = COUNT_FIELD_W'(count_reg);

endmodule

`default_nettype wire

// ----- hdl/rmfw_checker.sv -----
// Port-level checker for the recursive mutex block and its bind statement.
// Depends on rmfw_pkg and reentrant_mutex_fifo_waiters_assert.svh.
`default_nettype none
`include "reentrant_mutex_fifo_waiters_assert.svh"

module rmfw_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               rsp_valid,
    input wire logic                               rsp_ready,
    input wire logic [rmfw_pkg::STATUS_W-1:0]      status,
    input wire logic                               woken_valid,
    input wire logic [rmfw_pkg::ID_FIELD_W-1:0]    woken_id,
    input wire logic                               held_now,
    input wire logic [rmfw_pkg::COUNT_FIELD_W-1:0] repeat_now
);
    import rmfw_pkg::*;

    `RMFW_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(woken_id), "response item changed while stalled")
    `RMFW_ASSERT_NOW(a_woken_on_free, rsp_valid && woken_valid, status == ST_FREED, "waiter woken on a step that did not free the lock")
    `RMFW_ASSERT_NOW(a_woken_id_zero, rsp_valid && !woken_valid, woken_id == '0, "woken id not zero without a woken waiter")
    `RMFW_ASSERT_NOW(a_grant_count, rsp_valid && status == ST_GRANTED, held_now && repeat_now == COUNT_FIELD_W'(1), "grant did not leave a held lock with count one")
    `RMFW_ASSERT_NOW(a_free_count, rsp_valid && !held_now, repeat_now == '0, "free lock reports a nonzero count")

endmodule

bind reentrant_mutex_fifo_waiters rmfw_checker u_rmfw_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .status      (rsp.status),
    .woken_valid (rsp.woken_valid),
    .woken_id    (rsp.woken_id),
    .held_now    (rsp.held_now),
    .repeat_now  (rsp.repeat_now)
);

`default_nettype wire
